// ----- rtl/pflh_pkg.sv -----
// ----------------------------------------------------------------------------
// pflh_pkg
// shared constants, codes and control types of the latency histogram
// ----------------------------------------------------------------------------
`default_nettype none
package pflh_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int NUM_BUCKETS   = 27;
  localparam int RTT_SHIFT     = 3;

  localparam int RTT_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int KEY_W   = 2 * ADDR_W;
  localparam int CNT_W   = 64;
  localparam int ENTRY_W = 10;
  localparam int BKT_W   = 5;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CLR_W   = $clog2(NUM_BUCKETS);
  localparam int CADR_W  = $clog2(TABLE_ENTRIES * NUM_BUCKETS);
  localparam int MIC_W   = RTT_W - RTT_SHIFT;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_NEW     = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CLEAR,
    S_CNT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    key_rd;
    logic    idx_inc;
    logic    ins;
    logic    clr_wr;
    logic    cnt_rd;
    logic    cnt_wr;
    logic    res_zero;
    logic    st_we;
    status_t st;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic socket;
    logic scan_end;
    logic full;
    logic match;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/per_flow_log2_latency_histogram.sv -----
// ----------------------------------------------------------------------------
// per_flow_log2_latency_histogram
// per address pair log2 histogram of round-trip times
// ----------------------------------------------------------------------------
// Each input beat gives one result beat. An event searches the key table
// linearly over the filled entries, with a read state and a compare state
// for each entry. An ignored event skips the scan, and a hit reads and then
// writes its bucket counter. A drop on a full table follows a scan of all
// entries, and a new entry follows that scan with a clear of its 27 bucket
// counters, one per cycle. A stalled result holds back the next result,
// but the next event is taken while a result waits in the output register.
`default_nettype none
module per_flow_log2_latency_histogram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_socket_present,
  input  wire logic [pflh_pkg::RTT_W-1:0]  in_rtt_eighth_us,
  input  wire logic [pflh_pkg::ADDR_W-1:0] in_src_addr,
  input  wire logic [pflh_pkg::ADDR_W-1:0] in_dst_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [pflh_pkg::ENTRY_W-1:0]     out_entry_index,
  output logic [pflh_pkg::BKT_W-1:0]       out_bucket,
  output logic [pflh_pkg::CNT_W-1:0]       out_new_count
);
  import pflh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pflh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pflh_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_socket_present (in_socket_present),
    .in_rtt_eighth_us  (in_rtt_eighth_us),
    .in_src_addr       (in_src_addr),
    .in_dst_addr       (in_dst_addr),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_index   (out_entry_index),
    .out_bucket        (out_bucket),
    .out_new_count     (out_new_count)
  );

endmodule
`default_nettype wire

// ----- rtl/pflh_ram.sv -----
// ----------------------------------------------------------------------------
// pflh_ram
// generic single write port, single registered read port memory
// ----------------------------------------------------------------------------
`default_nettype none
module pflh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pflh_ctrl.sv -----
// ----------------------------------------------------------------------------
// pflh_ctrl
// sequencer: key scan, insert with bucket clear, counter update, result
// ----------------------------------------------------------------------------
`default_nettype none
module pflh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pflh_pkg::sts_t sts,
  output pflh_pkg::cmd_t     cmd
);
  import pflh_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_HIT;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (!sts.socket) begin
          cmd.st_we    = 1'b1;
          cmd.st       = ST_IGNORED;
          cmd.res_zero = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.scan_end) begin
          cmd.st_we = 1'b1;
          if (sts.full) begin
            cmd.st       = ST_FULL;
            cmd.res_zero = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.st    = ST_NEW;
            cmd.ins   = 1'b1;
            state_nxt = S_CLEAR;
          end
        end else begin
          cmd.key_rd = 1'b1;
          state_nxt  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.st_we  = 1'b1;
          cmd.st     = ST_HIT;
          cmd.cnt_rd = 1'b1;
          state_nxt  = S_CNT_WR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pflh_dp.sv -----
// ----------------------------------------------------------------------------
// pflh_dp
// datapath: bucket select, key table, counter memory, result register
// ----------------------------------------------------------------------------
`default_nettype none
module pflh_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_socket_present,
  input  wire logic [pflh_pkg::RTT_W-1:0]  in_rtt_eighth_us,
  input  wire logic [pflh_pkg::ADDR_W-1:0] in_src_addr,
  input  wire logic [pflh_pkg::ADDR_W-1:0] in_dst_addr,
  input  wire pflh_pkg::cmd_t              cmd,
  output pflh_pkg::sts_t                   sts,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [pflh_pkg::ENTRY_W-1:0]     out_entry_index,
  output logic [pflh_pkg::BKT_W-1:0]       out_bucket,
  output logic [pflh_pkg::CNT_W-1:0]       out_new_count
);
  import pflh_pkg::*;

  logic              sock_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  logic [FILL_W-1:0] idx_r;
  logic [FILL_W-1:0] fill_r;
  logic [CLR_W-1:0]  clr_r;
  status_t           st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  status_t           out_st_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [BKT_W-1:0]  out_bkt_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [MIC_W-1:0]  micros;
  logic [KEY_W-1:0]  key_rdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CADR_W-1:0] cnt_addr;
  logic [BKT_W-1:0]  bkt_sel;

  // floor log2, zero gives zero, saturated at the last bucket
  always_comb begin
    micros  = in_rtt_eighth_us[RTT_W-1:RTT_SHIFT];
    bkt_nxt = '0;
    for (int i = 1; i < MIC_W; i++) begin
      if (micros[i]) begin
        bkt_nxt = (i > NUM_BUCKETS - 1) ? BKT_W'(NUM_BUCKETS - 1) : BKT_W'(i);
      end
    end
  end

  assign bkt_sel  = cmd.clr_wr ? BKT_W'(clr_r) : bkt_r;
  assign cnt_addr = CADR_W'(idx_r[IDX_W-1:0]) * CADR_W'(NUM_BUCKETS) + CADR_W'(bkt_sel);
  assign cnt_inc  = cnt_rdata + CNT_W'(1);
  assign cnt_wdata = cmd.clr_wr ? ((BKT_W'(clr_r) == bkt_r) ? CNT_W'(1) : '0) : cnt_inc;

  pflh_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.ins),
    .waddr (fill_r[IDX_W-1:0]),
    .wdata (key_r),
    .re    (cmd.key_rd),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  pflh_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES * NUM_BUCKETS)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.cnt_wr),
    .waddr (cnt_addr),
    .wdata (cnt_wdata),
    .re    (cmd.cnt_rd),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sock_r <= in_socket_present;
      key_r  <= {in_src_addr, in_dst_addr};
      bkt_r  <= bkt_nxt;
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r  <= idx_r + FILL_W'(1);
    end
    if (cmd.ins) begin
      clr_r <= '0;
      cnt_r <= CNT_W'(1);
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + CLR_W'(1);
    end
    if (cmd.cnt_wr) begin
      cnt_r <= cnt_inc;
    end
    if (cmd.res_zero) begin
      cnt_r <= '0;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st;
    end
    if (cmd.out_load) begin
      out_st_r  <= st_r;
      out_idx_r <= (st_r == ST_HIT || st_r == ST_NEW) ? idx_r[IDX_W-1:0] : '0;
      out_bkt_r <= (st_r == ST_HIT || st_r == ST_NEW) ? bkt_r : '0;
      out_cnt_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.socket   = sock_r;
  assign sts.scan_end = (idx_r == fill_r);
  assign sts.full     = (fill_r == FILL_W'(TABLE_ENTRIES));
  assign sts.match    = (key_rdata == key_r);
  assign sts.clr_last = (clr_r == CLR_W'(NUM_BUCKETS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_entry_index = ENTRY_W'(out_idx_r);
  assign out_bucket      = out_bkt_r;
  assign out_new_count   = out_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_ENTRIES))
    else $error("table fill beyond capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("insert did not grow the table");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_FULL || out_st_r == ST_IGNORED)
      |-> out_cnt_r == '0 && out_idx_r == '0)
    else $error("dropped beat carries a count");

endmodule
`default_nettype wire

// ----- tb/sv/per_flow_log2_latency_histogram_test.sv -----
// ----------------------------------------------------------------------------
// per_flow_log2_latency_histogram_test
// self-checking bench for the per address pair log2 round-trip histogram
// ----------------------------------------------------------------------------
// A directed table covers ignored events, time extremes and the edges of the
// bucket range. Random events then draw from a small pool of address pairs.
// Last, the key table is filled past its capacity so that dropped events and
// hits in a full table are seen. A local model of the table and counters gives
// the expected result where a row gives none. Both sides idle at random outside the calm stretch.
`timescale 1ns / 100ps
`default_nettype none
module per_flow_log2_latency_histogram_test;
  import pflh_pkg::*;

  typedef struct {
    status_t                status;
    logic [ENTRY_W-1:0]     entry;
    logic [BKT_W-1:0]       bucket;
    logic [CNT_W-1:0]       count;
  } tally_t;

  typedef struct {
    logic               sock;
    logic [RTT_W-1:0]   rtt;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic               typed;
    tally_t             want;
  } event_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_socket_present;
  logic [RTT_W-1:0] in_rtt_eighth_us;
  logic [ADDR_W-1:0] in_src_addr;
  logic [ADDR_W-1:0] in_dst_addr;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [ENTRY_W-1:0] out_entry_index;
  logic [BKT_W-1:0] out_bucket;
  logic [CNT_W-1:0] out_new_count;

  bit             flow_used [TABLE_ENTRIES];
  logic [KEY_W-1:0] flow_key [TABLE_ENTRIES];
  logic [CNT_W-1:0] flow_hist [TABLE_ENTRIES][NUM_BUCKETS];

  tally_t pending_tallies[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;

  per_flow_log2_latency_histogram DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_socket_present(in_socket_present), .in_rtt_eighth_us(in_rtt_eighth_us),
    .in_src_addr(in_src_addr), .in_dst_addr(in_dst_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_entry_index(out_entry_index),
    .out_bucket(out_bucket), .out_new_count(out_new_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tally_t tally_event(logic sock, logic [RTT_W-1:0] rtt,
                                         logic [ADDR_W-1:0] src,
                                         logic [ADDR_W-1:0] dst);
    tally_t r;
    logic [RTT_W-1:0] micros;
    int lg;
    int slot;
    int spare;
    logic [KEY_W-1:0] k;
    r = '{ST_IGNORED, '0, '0, '0};
    lg = 0;
    slot = -1;
    spare = -1;
    k = {src, dst};
    if (!sock) return r;
    micros = rtt >> RTT_SHIFT;
    for (int b = 0; b < RTT_W; b++) if (micros[b]) lg = b;
    if (lg > NUM_BUCKETS - 1) lg = NUM_BUCKETS - 1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (flow_used[i]) begin
        if (slot < 0 && flow_key[i] == k) slot = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (slot >= 0) begin
      r.status = ST_HIT;
    end else if (spare >= 0) begin
      slot = spare;
      flow_used[slot] = 1'b1;
      flow_key[slot] = k;
      for (int b = 0; b < NUM_BUCKETS; b++) flow_hist[slot][b] = '0;
      r.status = ST_NEW;
    end else begin
      r.status = ST_FULL;
      return r;
    end
    flow_hist[slot][lg] = flow_hist[slot][lg] + 1'b1;
    r.entry = slot[ENTRY_W-1:0];
    r.bucket = lg[BKT_W-1:0];
    r.count = flow_hist[slot][lg];
    return r;
  endfunction

  task automatic send_event(event_row_t row);
    tally_t t;
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_socket_present <= row.sock;
    in_rtt_eighth_us <= row.rtt;
    in_src_addr <= row.src;
    in_dst_addr <= row.dst;
    do @(posedge clk); while (in_stall);
    t = tally_event(row.sock, row.rtt, row.src, row.dst);
    pending_tallies.push_back(row.typed ? row.want : t);
  endtask

  // checks each result beat against the oldest pending tally
  always @(posedge clk) begin
    tally_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 26);
      if (out_valid && !out_stall) begin
        if (pending_tallies.size() == 0) begin
          $error("result beat with nothing pending");
          fail_count++;
        end else begin
          w = pending_tallies.pop_front();
          if (out_status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, out_status);
            fail_count++;
          end
          if (out_entry_index !== w.entry) begin
            $error("entry_index: expected %0d, got %0d", w.entry, out_entry_index);
            fail_count++;
          end
          if (out_bucket !== w.bucket) begin
            $error("bucket: expected %0d, got %0d", w.bucket, out_bucket);
            fail_count++;
          end
          if (out_new_count !== w.count) begin
            $error("new_count: expected %0d, got %0d", w.count, out_new_count);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    event_row_t directed [12];
    event_row_t row;
    logic [ADDR_W-1:0] pool_src [40];
    logic [ADDR_W-1:0] pool_dst [40];
    int p;
    int waited;
    directed[0]  = '{1'b0, '1, '1, '1, 1'b1, '{ST_IGNORED, 10'd0, 5'd0, 64'd0}};
    directed[1]  = '{1'b1, '0, '0, '0, 1'b1, '{ST_NEW, 10'd0, 5'd0, 64'd1}};
    directed[2]  = '{1'b1, 32'd7, '0, '0, 1'b1, '{ST_HIT, 10'd0, 5'd0, 64'd2}};
    directed[3]  = '{1'b1, 32'd8, '0, '0, 1'b1, '{ST_HIT, 10'd0, 5'd0, 64'd3}};
    directed[4]  = '{1'b1, 32'd16, '0, '0, 1'b1, '{ST_HIT, 10'd0, 5'd1, 64'd1}};
    directed[5]  = '{1'b1, '1, '1, '1, 1'b1, '{ST_NEW, 10'd1, 5'd26, 64'd1}};
    directed[6]  = '{1'b1, 32'h2000_0000, '1, '1, 1'b1,
                     '{ST_HIT, 10'd1, 5'd26, 64'd2}};
    directed[7]  = '{1'b1, 32'h1000_0000, '1, '1, 1'b1,
                     '{ST_HIT, 10'd1, 5'd25, 64'd1}};
    directed[8]  = '{1'b0, 32'h1234, 32'h5, 32'h6, 1'b1,
                     '{ST_IGNORED, 10'd0, 5'd0, 64'd0}};
    directed[9]  = '{1'b1, 32'd100, '0, '1, 1'b0, '{ST_HIT, '0, '0, '0}};
    directed[10] = '{1'b1, 32'h0fff_ffff, '1, '0, 1'b0, '{ST_HIT, '0, '0, '0}};
    directed[11] = '{1'b1, 32'h1234_5678, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b0,
                     '{ST_HIT, '0, '0, '0}};
    for (int i = 0; i < 40; i++) begin
      pool_src[i] = $urandom;
      pool_dst[i] = $urandom;
    end
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_socket_present <= 1'b0;
    in_rtt_eighth_us <= '0;
    in_src_addr <= '0;
    in_dst_addr <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_event(directed[i]);

    // random events over a small pool of flows
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 250);
      p = $urandom_range(39);
      row.sock = ($urandom_range(99) < 90);
      row.rtt = $urandom >> $urandom_range(31);
      row.src = pool_src[p];
      row.dst = pool_dst[p];
      row.typed = 1'b0;
      if ($urandom_range(99) < 5) begin
        row.src = $urandom;
        row.dst = $urandom;
      end
      send_event(row);
    end
    calm = 1'b0;

    // fill the table past capacity, then hit and miss in a full table
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      row = '{1'b1, $urandom, 32'hc000_0000 | n, ~n, 1'b0, '{ST_HIT, '0, '0, '0}};
      send_event(row);
    end
    for (int n = 0; n < 16; n++) begin
      p = $urandom_range(39);
      row = '{1'b1, $urandom >> $urandom_range(31), pool_src[p], pool_dst[p], 1'b0,
              '{ST_HIT, '0, '0, '0}};
      if (n % 3 == 0) row.src = $urandom;
      if (n % 5 == 0) row.sock = 1'b0;
      send_event(row);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_tallies.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_tallies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
